FILE: rtl/core/bcdep_pkg.sv
// package for the bcd clock reading to epoch seconds core
// pipeline depth, arithmetic constants, month table and bcd decode
// no dependencies
`default_nettype none

package bcdep_pkg;

   // number of register stages from request to response
   localparam int PIPE_DEPTH = 9;

   // calendar constants
   localparam int EPOCH_YEAR   = 1970;
   localparam int LEAPS_1969   = 477;   // leap years in 1..1969
   localparam int DAYS_IN_YEAR = 365;

   // division by 25 as multiply by reciprocal, exact for inputs below 43690
   localparam int RECIP_25    = 5243;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = 26;

   // control from the stage controller to the datapath
   typedef struct packed {
      logic [PIPE_DEPTH-1:0] valid;
      logic [PIPE_DEPTH-1:0] load;
      logic                  in_ready;
   } pipe_ctrl_type;

   // two bcd digits to binary, nibbles above nine taken at face value
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'b0, b[7:4]} * 8'd10;
      return tens + {4'b0, b[3:0]};
   endfunction

   // days in the year before the first of a month, month index from zero
   function automatic logic [8:0] days_before_month(input logic [3:0] idx);
      logic [8:0] d;
      case (idx)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bcdep_intf.sv
// valid/ready channel interfaces for the request and response sides
// no dependencies
`default_nettype none

interface bcdep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] century_bcd;
   logic [7:0] year_bcd;
   logic [7:0] month_bcd;
   logic [7:0] day_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] minute_bcd;
   logic [7:0] second_bcd;

   modport source (
      output valid, century_bcd, year_bcd, month_bcd, day_bcd,
             hour_bcd, minute_bcd, second_bcd,
      input  ready
   );
   modport sink (
      input  valid, century_bcd, year_bcd, month_bcd, day_bcd,
             hour_bcd, minute_bcd, second_bcd,
      output ready
   );
endinterface

interface bcdep_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [39:0] epoch_seconds;
   logic               month_bad;

   modport source (
      output valid, epoch_seconds, month_bad,
      input  ready
   );
   modport sink (
      input  valid, epoch_seconds, month_bad,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/bcd_rtc_to_epoch_seconds_core.sv
// Converts a BCD real-time-clock reading (century, year, month, day,
// hour, minute, second) into signed seconds since 1970-01-01 00:00.
//
// Channels: req_chan takes one reading per transaction, rsp_chan returns
// one result per reading in order: epoch_seconds (40-bit two's complement)
// and month_bad, set with zero seconds when the month is outside 1..12.
// Pipeline: nine register stages, one per step of the day count and of
// the hour, minute and second scaling.
// Throughput: one transaction per cycle while req_chan.ready is high;
// every stage is a register with its own valid bit, so a new reading
// enters while earlier ones are in flight.
// Stall: when the sink holds ready low, the output stage holds its result
// and empty stages behind it keep filling; req_chan.ready falls only once
// all nine stages hold a result.
// Reset: synchronous, clears all stage valid bits; no result is in flight
// after it.
// depends on bcdep_pkg, bcdep_intf, bcdep_pipe_ctrl
`default_nettype none

module bcd_rtc_to_epoch_seconds_core (
   input wire logic     clock,
   input wire logic     reset,
   bcdep_req_if.sink    req_chan,
   bcdep_rsp_if.source  rsp_chan
);

   localparam int PW = bcdep_pkg::PROD_W;
   localparam int RS = bcdep_pkg::RECIP_SHIFT;

   bcdep_pkg::pipe_ctrl_type ctrl;

   bcdep_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .out_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   assign req_chan.ready = ctrl.in_ready;

   // stage 1: decode bcd bytes and check the month
   logic [7:0] mon_dec;
   logic [7:0] mon_minus;
   logic [7:0] s1_cen_ff, s1_yr_ff, s1_day_ff, s1_hr_ff, s1_mi_ff, s1_se_ff;
   logic [7:0] s1_cen_in, s1_yr_in, s1_day_in, s1_hr_in, s1_mi_in, s1_se_in;
   logic [3:0] s1_mon_idx_ff, s1_mon_idx_in;
   logic       s1_le2_ff, s1_le2_in;
   logic       s1_bad_ff, s1_bad_in;

   assign mon_dec       = bcdep_pkg::bcd_to_bin(req_chan.month_bcd);
   assign mon_minus     = mon_dec - 8'd1;
   assign s1_cen_in     = bcdep_pkg::bcd_to_bin(req_chan.century_bcd);
   assign s1_yr_in      = bcdep_pkg::bcd_to_bin(req_chan.year_bcd);
   assign s1_day_in     = bcdep_pkg::bcd_to_bin(req_chan.day_bcd);
   assign s1_hr_in      = bcdep_pkg::bcd_to_bin(req_chan.hour_bcd);
   assign s1_mi_in      = bcdep_pkg::bcd_to_bin(req_chan.minute_bcd);
   assign s1_se_in      = bcdep_pkg::bcd_to_bin(req_chan.second_bcd);
   assign s1_mon_idx_in = mon_minus[3:0];
   assign s1_le2_in     = (mon_dec <= 8'd2);
   assign s1_bad_in     = (mon_dec == 8'd0) || (mon_dec > 8'd12);

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_cen_ff     <= s1_cen_in;
         s1_yr_ff      <= s1_yr_in;
         s1_day_ff     <= s1_day_in;
         s1_hr_ff      <= s1_hr_in;
         s1_mi_ff      <= s1_mi_in;
         s1_se_ff      <= s1_se_in;
         s1_mon_idx_ff <= s1_mon_idx_in;
         s1_le2_ff     <= s1_le2_in;
         s1_bad_ff     <= s1_bad_in;
      end
   end

   // stage 2: full year and days before the month
   logic [14:0] s2_year_ff, s2_year_in;
   logic [8:0]  s2_dbm_ff, s2_dbm_in;
   logic [7:0]  s2_day_ff, s2_hr_ff, s2_mi_ff, s2_se_ff;
   logic        s2_le2_ff, s2_bad_ff;

   assign s2_year_in = {7'b0, s1_cen_ff} * 15'd100 + {7'b0, s1_yr_ff};
   assign s2_dbm_in  = bcdep_pkg::days_before_month(s1_mon_idx_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_year_ff <= s2_year_in;
         s2_dbm_ff  <= s2_dbm_in;
         s2_day_ff  <= s1_day_ff;
         s2_hr_ff   <= s1_hr_ff;
         s2_mi_ff   <= s1_mi_ff;
         s2_se_ff   <= s1_se_ff;
         s2_le2_ff  <= s1_le2_ff;
         s2_bad_ff  <= s1_bad_ff;
      end
   end

   // stage 3: last year for the leap count and year offset from the epoch
   logic [14:0]        s3_last_ff, s3_last_in;
   logic               s3_last_ge_ff, s3_last_ge_in;
   logic signed [15:0] s3_yoff_ff, s3_yoff_in;
   logic [8:0]         s3_dbm_ff;
   logic [7:0]         s3_day_ff, s3_hr_ff, s3_mi_ff, s3_se_ff;
   logic               s3_bad_ff;

   assign s3_last_in    = s2_year_ff - {14'b0, s2_le2_ff};
   assign s3_last_ge_in = s2_le2_ff ? (s2_year_ff >= 15'(bcdep_pkg::EPOCH_YEAR + 1))
                                    : (s2_year_ff >= 15'(bcdep_pkg::EPOCH_YEAR));
   assign s3_yoff_in    = $signed({1'b0, s2_year_ff}) - $signed(16'(bcdep_pkg::EPOCH_YEAR));

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_last_ff    <= s3_last_in;
         s3_last_ge_ff <= s3_last_ge_in;
         s3_yoff_ff    <= s3_yoff_in;
         s3_dbm_ff     <= s2_dbm_ff;
         s3_day_ff     <= s2_day_ff;
         s3_hr_ff      <= s2_hr_ff;
         s3_mi_ff      <= s2_mi_ff;
         s3_se_ff      <= s2_se_ff;
         s3_bad_ff     <= s2_bad_ff;
      end
   end

   // stage 4: reciprocal products for /100 and /400, whole years in days
   logic [PW-1:0]      s4_q100p_ff, s4_q100p_in;
   logic [PW-1:0]      s4_q400p_ff, s4_q400p_in;
   logic [12:0]        s4_l4_ff;
   logic               s4_last_ge_ff;
   logic signed [23:0] s4_base_ff, s4_base_in;
   logic [8:0]         s4_dbm_ff;
   logic [7:0]         s4_day_ff, s4_hr_ff, s4_mi_ff, s4_se_ff;
   logic               s4_bad_ff;

   // n/100 = (n/4)/25 and n/400 = (n/16)/25
   assign s4_q100p_in = {13'b0, s3_last_ff[14:2]} * PW'(bcdep_pkg::RECIP_25);
   assign s4_q400p_in = {15'b0, s3_last_ff[14:4]} * PW'(bcdep_pkg::RECIP_25);
   assign s4_base_in  = $signed({{8{s3_yoff_ff[15]}}, s3_yoff_ff})
                        * $signed(24'(bcdep_pkg::DAYS_IN_YEAR));

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_q100p_ff   <= s4_q100p_in;
         s4_q400p_ff   <= s4_q400p_in;
         s4_l4_ff      <= s3_last_ff[14:2];
         s4_last_ge_ff <= s3_last_ge_ff;
         s4_base_ff    <= s4_base_in;
         s4_dbm_ff     <= s3_dbm_ff;
         s4_day_ff     <= s3_day_ff;
         s4_hr_ff      <= s3_hr_ff;
         s4_mi_ff      <= s3_mi_ff;
         s4_se_ff      <= s3_se_ff;
         s4_bad_ff     <= s3_bad_ff;
      end
   end

   // stage 5: leap days since 1970 and the day count without them
   logic [PW-RS-1:0]   q100, q400;
   logic [13:0]        leaps_sum;
   logic [11:0]        s5_leaps_ff, s5_leaps_in;
   logic signed [23:0] s5_partial_ff, s5_partial_in;
   logic [7:0]         s5_hr_ff, s5_mi_ff, s5_se_ff;
   logic               s5_bad_ff;

   assign q100      = s4_q100p_ff[PW-1:RS];
   assign q400      = s4_q400p_ff[PW-1:RS];
   assign leaps_sum = {1'b0, s4_l4_ff} - 14'(q100) + 14'(q400)
                      - 14'(bcdep_pkg::LEAPS_1969);
   assign s5_leaps_in   = s4_last_ge_ff ? leaps_sum[11:0] : 12'd0;
   assign s5_partial_in = s4_base_ff + $signed({15'b0, s4_dbm_ff})
                          + $signed({16'b0, s4_day_ff}) - 24'sd1;

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         s5_leaps_ff   <= s5_leaps_in;
         s5_partial_ff <= s5_partial_in;
         s5_hr_ff      <= s4_hr_ff;
         s5_mi_ff      <= s4_mi_ff;
         s5_se_ff      <= s4_se_ff;
         s5_bad_ff     <= s4_bad_ff;
      end
   end

   // stage 6: total day count
   logic signed [23:0] s6_days_ff, s6_days_in;
   logic [7:0]         s6_hr_ff, s6_mi_ff, s6_se_ff;
   logic               s6_bad_ff;

   assign s6_days_in = s5_partial_ff + $signed({12'b0, s5_leaps_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         s6_days_ff <= s6_days_in;
         s6_hr_ff   <= s5_hr_ff;
         s6_mi_ff   <= s5_mi_ff;
         s6_se_ff   <= s5_se_ff;
         s6_bad_ff  <= s5_bad_ff;
      end
   end

   // stage 7: hours
   logic signed [28:0] s7_hours_ff, s7_hours_in;
   logic [7:0]         s7_mi_ff, s7_se_ff;
   logic               s7_bad_ff;

   assign s7_hours_in = $signed({{5{s6_days_ff[23]}}, s6_days_ff}) * 29'sd24
                        + $signed({21'b0, s6_hr_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         s7_hours_ff <= s7_hours_in;
         s7_mi_ff    <= s6_mi_ff;
         s7_se_ff    <= s6_se_ff;
         s7_bad_ff   <= s6_bad_ff;
      end
   end

   // stage 8: minutes
   logic signed [34:0] s8_mins_ff, s8_mins_in;
   logic [7:0]         s8_se_ff;
   logic               s8_bad_ff;

   assign s8_mins_in = $signed({{6{s7_hours_ff[28]}}, s7_hours_ff}) * 35'sd60
                       + $signed({27'b0, s7_mi_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         s8_mins_ff <= s8_mins_in;
         s8_se_ff   <= s7_se_ff;
         s8_bad_ff  <= s7_bad_ff;
      end
   end

   // stage 9: seconds, forced to zero on a bad month; this is the output register
   logic signed [39:0] secs_full;
   logic signed [39:0] s9_secs_ff, s9_secs_in;
   logic               s9_bad_ff;

   assign secs_full  = $signed({{5{s8_mins_ff[34]}}, s8_mins_ff}) * 40'sd60
                       + $signed({32'b0, s8_se_ff});
   assign s9_secs_in = s8_bad_ff ? 40'sd0 : secs_full;

   always_ff @(posedge clock) begin
      if (ctrl.load[8]) begin
         s9_secs_ff <= s9_secs_in;
         s9_bad_ff  <= s8_bad_ff;
      end
   end

   assign rsp_chan.valid         = ctrl.valid[bcdep_pkg::PIPE_DEPTH-1];
   assign rsp_chan.epoch_seconds = s9_secs_ff;
   assign rsp_chan.month_bad     = s9_bad_ff;

`ifndef SYNTH
   // a bad month always carries zero seconds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.month_bad) |-> (rsp_chan.epoch_seconds == 40'sd0))
      else $error("bad month with non-zero seconds");

   // a stalled response stays put until the sink takes it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.epoch_seconds)
          && $stable(rsp_chan.month_bad)))
      else $error("response changed while stalled");

   // the request side is never held off while the sink is taking responses
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.ready |-> req_chan.ready)
      else $error("request stalled with a ready sink");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/bcdep_pipe_ctrl.sv
// stage valid bits and load enables for the conversion pipeline
// depends on bcdep_pkg
`default_nettype none

module bcdep_pipe_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic                    out_ready,
   output bcdep_pkg::pipe_ctrl_type     ctrl
);

   localparam int D = bcdep_pkg::PIPE_DEPTH;

   logic [D-1:0] valid_ff;
   logic [D-1:0] valid_in;
   logic [D-1:0] load;

   // a stage may load when empty or when the stage after it loads
   always_comb begin
      load[D-1] = !valid_ff[D-1] || out_ready;
      for (int i = D - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   // valid bits follow the data
   always_comb begin
      valid_in[0] = load[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < D; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.valid    = valid_ff;
   assign ctrl.load     = load;
   assign ctrl.in_ready = load[0];

`ifndef SYNTH
   // reset empties every stage
   assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   // back-pressure on the request side only with a full pipe and a stalled sink
   assert property (@(posedge clock) disable iff (reset)
      !load[0] |-> ((&valid_ff) && !out_ready))
      else $error("request stalled with room in the pipeline");

   // an accepted transaction lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (in_valid && load[0]) |=> valid_ff[0])
      else $error("accepted transaction lost at first stage");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for bcd_rtc_to_epoch_seconds_core: clock readings in, epoch seconds out
// predicts each result from the reading itself and checks every response in order
// depends on bcdep_pkg, bcdep_intf and the core
`timescale 1ns / 1ps

module tb;

   // one clock reading as it travels on the request channel
   typedef struct packed {
      logic [7:0] century_bcd;
      logic [7:0] year_bcd;
      logic [7:0] month_bcd;
      logic [7:0] day_bcd;
      logic [7:0] hour_bcd;
      logic [7:0] minute_bcd;
      logic [7:0] second_bcd;
   } reading_type;

   typedef struct packed {
      logic signed [39:0] epoch_seconds;
      logic               month_bad;
   } epoch_result_type;

   localparam int  UNIX_EPOCH_YEAR = 1970;
   localparam int  TAIL_CYCLES     = bcdep_pkg::PIPE_DEPTH + 8;
   localparam int  HOLD_CYCLES     = 120;

   logic clock = 1'b0;
   logic reset;
   logic idle_on;
   logic rsp_hold;

   epoch_result_type pending_epochs[$];
   int               mismatch_count   = 0;
   int               readings_sent    = 0;
   int               results_checked  = 0;
   int               bad_months_seen  = 0;
   int               pre_epoch_seen   = 0;

   bcdep_req_if req_chan_if ();
   bcdep_rsp_if rsp_chan_if ();

   bcd_rtc_to_epoch_seconds_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan_if),
      .rsp_chan (rsp_chan_if)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // two bcd digits, nibbles above nine taken at face value
   function automatic longint from_bcd(input logic [7:0] b);
      return longint'(b[7:4]) * 10 + longint'(b[3:0]);
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned n);
      logic [3:0] tens;
      logic [3:0] ones;
      tens = 4'(n / 10);
      ones = 4'(n % 10);
      return {tens, ones};
   endfunction

   // days in the year before the first of month m, m from 1 to 12
   function automatic longint days_ahead_of_month(input longint m);
      case (m)
         1:       return 0;
         2:       return 31;
         3:       return 59;
         4:       return 90;
         5:       return 120;
         6:       return 151;
         7:       return 181;
         8:       return 212;
         9:       return 243;
         10:      return 273;
         11:      return 304;
         default: return 334;
      endcase
   endfunction

   // gregorian leap years in 1..n
   function automatic longint leap_years_through(input longint n);
      return n / 4 - n / 100 + n / 400;
   endfunction

   function automatic epoch_result_type epoch_of_reading(input reading_type r);
      epoch_result_type res;
      longint           mon;
      longint           year;
      longint           last_year;
      longint           days;
      longint           secs;
      mon = from_bcd(r.month_bcd);
      res.month_bad     = 1'b0;
      res.epoch_seconds = '0;
      if (mon < 1 || mon > 12) begin
         res.month_bad = 1'b1;
         return res;
      end
      year = from_bcd(r.century_bcd) * 100 + from_bcd(r.year_bcd);
      days = (year - UNIX_EPOCH_YEAR) * 365 + days_ahead_of_month(mon)
             + from_bcd(r.day_bcd) - 1;
      // the leap day of this year only counts from march on
      last_year = (mon <= 2) ? year - 1 : year;
      if (last_year >= UNIX_EPOCH_YEAR) begin
         days += leap_years_through(last_year) - leap_years_through(UNIX_EPOCH_YEAR - 1);
      end
      secs = ((days * 24 + from_bcd(r.hour_bcd)) * 60 + from_bcd(r.minute_bcd)) * 60
             + from_bcd(r.second_bcd);
      res.epoch_seconds = secs[39:0];
      return res;
   endfunction

   // a plausible calendar reading, mostly around the last few centuries
   function automatic reading_type random_valid_reading();
      reading_type r;
      int unsigned cen;
      case ($urandom_range(0, 3))
         0:       cen = 19;
         1:       cen = 20;
         2:       cen = 21;
         default: cen = $urandom_range(0, 99);
      endcase
      r.century_bcd = to_bcd(cen);
      r.year_bcd    = to_bcd($urandom_range(0, 99));
      r.month_bcd   = to_bcd($urandom_range(1, 12));
      r.day_bcd     = to_bcd($urandom_range(1, 31));
      r.hour_bcd    = to_bcd($urandom_range(0, 23));
      r.minute_bcd  = to_bcd($urandom_range(0, 59));
      r.second_bcd  = to_bcd($urandom_range(0, 59));
      return r;
   endfunction

   // noise, bad months and readings with a field out of range
   function automatic reading_type random_broken_reading();
      reading_type r;
      logic [63:0] raw;
      r   = random_valid_reading();
      raw = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
         0: r = raw[55:0];
         1: begin
            case ($urandom_range(0, 2))
               0:       r.month_bcd = 8'h00;
               1:       r.month_bcd = to_bcd($urandom_range(13, 99));
               default: r.month_bcd = 8'($urandom_range(32, 255));
            endcase
         end
         2: begin
            case ($urandom_range(0, 5))
               0:       r.century_bcd = raw[7:0];
               1:       r.year_bcd    = raw[7:0];
               2:       r.day_bcd     = raw[7:0];
               3:       r.hour_bcd    = raw[7:0];
               4:       r.minute_bcd  = raw[7:0];
               default: r.second_bcd  = raw[7:0];
            endcase
         end
         default: begin
            // every byte random but the month, which may use hex digits
            r = raw[55:0];
            if ($urandom_range(0, 1) == 1) begin
               r.month_bcd = to_bcd($urandom_range(1, 12));
            end else begin
               r.month_bcd = 8'($urandom_range(10, 12));
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("tb: mismatch at %0t: %s", $time, msg);
   endtask

   // one transaction on the request channel, with an optional idle burst first
   task automatic send_reading(input reading_type r);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_chan_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan_if.valid       <= 1'b1;
      req_chan_if.century_bcd <= r.century_bcd;
      req_chan_if.year_bcd    <= r.year_bcd;
      req_chan_if.month_bcd   <= r.month_bcd;
      req_chan_if.day_bcd     <= r.day_bcd;
      req_chan_if.hour_bcd    <= r.hour_bcd;
      req_chan_if.minute_bcd  <= r.minute_bcd;
      req_chan_if.second_bcd  <= r.second_bcd;
      @(posedge clock);
      while (!req_chan_if.ready) @(posedge clock);
      pending_epochs.push_back(epoch_of_reading(r));
      readings_sent++;
   endtask

   task automatic wait_for_results();
      req_chan_if.valid <= 1'b0;
      while (pending_epochs.size() != 0) @(posedge clock);
   endtask

   // response side: random stall bursts, or a long hold when asked
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      rsp_chan_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || rsp_hold) begin
            rsp_chan_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_chan_if.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_chan_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
         end else begin
            rsp_chan_if.ready <= 1'b1;
         end
      end
   end

   // compare each response with the oldest outstanding prediction
   always @(posedge clock) begin : check_results
      epoch_result_type want;
      if (!reset && rsp_chan_if.valid && rsp_chan_if.ready) begin
         if (pending_epochs.size() == 0) begin
            report_mismatch("response with no reading outstanding");
         end else begin
            want = pending_epochs.pop_front();
            results_checked++;
            if (want.month_bad) bad_months_seen++;
            if (!want.month_bad && want.epoch_seconds < 0) pre_epoch_seen++;
            if (rsp_chan_if.epoch_seconds !== want.epoch_seconds) begin
               report_mismatch($sformatf("epoch_seconds got %0d expected %0d",
                  rsp_chan_if.epoch_seconds, want.epoch_seconds));
            end
            if (rsp_chan_if.month_bad !== want.month_bad) begin
               report_mismatch($sformatf("month_bad got %b expected %b",
                  rsp_chan_if.month_bad, want.month_bad));
            end
         end
      end
   end

   // field extremes, leap rules, bad months and hex digits
   task automatic test_directed();
      send_reading({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
      send_reading({8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
      send_reading({8'h19, 8'h70, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h19, 8'h69, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59});
      send_reading({8'h19, 8'h70, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
      send_reading({8'h19, 8'h71, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h19, 8'h72, 8'h02, 8'h29, 8'h00, 8'h00, 8'h00});
      send_reading({8'h19, 8'h72, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h20, 8'h00, 8'h02, 8'h29, 8'h12, 8'h00, 8'h00});
      send_reading({8'h20, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h21, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h24, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h19, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h00});
      send_reading({8'h20, 8'h38, 8'h01, 8'h19, 8'h03, 8'h14, 8'h07});
      // month with hex digits: 0x0a and 0x0c are valid, 0x0d and 0x1f are not
      send_reading({8'h20, 8'h24, 8'h0a, 8'h15, 8'h10, 8'h30, 8'h00});
      send_reading({8'h20, 8'h24, 8'h0c, 8'h15, 8'h10, 8'h30, 8'h00});
      send_reading({8'h20, 8'h24, 8'h0d, 8'h15, 8'h10, 8'h30, 8'h00});
      send_reading({8'h20, 8'h24, 8'h13, 8'h15, 8'h10, 8'h30, 8'h00});
      send_reading({8'h20, 8'h24, 8'h1f, 8'h15, 8'h10, 8'h30, 8'h00});
      // hour, minute and second beyond their calendar range, day with a hex digit
      send_reading({8'h20, 8'h24, 8'h06, 8'h1f, 8'hff, 8'hff, 8'hff});
      // largest and smallest decodable readings
      send_reading({8'hff, 8'hff, 8'h12, 8'hff, 8'hff, 8'hff, 8'hff});
      send_reading({8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
      send_reading({8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00});
   endtask

   task automatic send_mixed_reading();
      if ($urandom_range(0, 9) < 6) begin
         send_reading(random_valid_reading());
      end else begin
         send_reading(random_broken_reading());
      end
   endtask

   task automatic test_mixed_traffic(input int count);
      for (int i = 0; i < count; i++) send_mixed_reading();
   endtask

   // response side held off while readings keep coming, so the input stalls
   task automatic test_output_backpressure(input int count);
      idle_on <= 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            for (int i = 0; i < count; i++) send_mixed_reading();
         end
      join
      wait_for_results();
      idle_on <= 1'b1;
   endtask

   // bursts of readings, each followed by a full drain of the pipeline
   task automatic test_drain_pauses(input int bursts, input int count);
      for (int b = 0; b < bursts; b++) begin
         for (int i = 0; i < count; i++) send_mixed_reading();
         wait_for_results();
      end
   endtask

   // back to back, no idling on either side
   task automatic test_steady_stream(input int count);
      idle_on <= 1'b0;
      for (int i = 0; i < count; i++) send_mixed_reading();
   endtask

   task automatic finish_run();
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d readings sent, %0d checked, %0d with a bad month, %0d before 1970",
         readings_sent, results_checked, bad_months_seen, pre_epoch_seen);
      $display("tb: covered random stalls, a long output hold, drains; %0d mismatches",
         mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   endtask

   // stimulus sequence
   initial begin
      reset                   <= 1'b1;
      idle_on                 <= 1'b1;
      rsp_hold                <= 1'b0;
      req_chan_if.valid       <= 1'b0;
      req_chan_if.century_bcd <= 8'h00;
      req_chan_if.year_bcd    <= 8'h00;
      req_chan_if.month_bcd   <= 8'h00;
      req_chan_if.day_bcd     <= 8'h00;
      req_chan_if.hour_bcd    <= 8'h00;
      req_chan_if.minute_bcd  <= 8'h00;
      req_chan_if.second_bcd  <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_mixed_traffic(900);
      test_output_backpressure(60);
      test_drain_pauses(3, 50);
      test_steady_stream(420);
      finish_run();
   end

   // run limit, well beyond the slowest correct run
   initial begin
      #5000000;
      $display("tb: run limit reached with %0d results outstanding", pending_epochs.size());
      $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/bcdep_pkg.sv
rtl/core/bcdep_intf.sv
rtl/core/bcdep_pipe_ctrl.sv
rtl/core/bcd_rtc_to_epoch_seconds_core.sv
test/tb.sv
